>>> design/irtc_pkg.sv
// ----------------------------------------------------------------------------
// IR timing to carrier periods: shared package
// Item types, queue entry type and arithmetic constants of the converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package irtc_pkg;

  localparam int unsigned DurW    = 16;
  localparam int unsigned CarrierW = 19;
  localparam int unsigned TotalW  = 32;
  localparam int unsigned PeriodW = 32;

  localparam logic [CarrierW-1:0] CarrierMin   = 19'd15000;
  localparam logic [CarrierW-1:0] CarrierMax   = 19'd500000;
  localparam logic [CarrierW-1:0] CarrierReset = 19'd38000;

  // Index of the only configuration register.
  localparam logic RegIdxCarrierHz = 1'b0;

  localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

  // Rounding bias, odd factor of one million and its scaled reciprocal.
  localparam logic [19:0] RoundBias  = 20'd500000;
  localparam logic [13:0] Divisor    = 14'd15625;
  localparam logic [31:0] Reciprocal = 32'd2251799813;
  localparam logic [15:0] DivisorX1  = 16'd15625;
  localparam logic [16:0] DivisorX2  = 17'd31250;

  typedef struct packed {
    logic [DurW-1:0] duration_us;
    logic            last_of_burst;
  } in_item_t;

  typedef struct packed {
    logic [PeriodW-1:0] carrier_periods;
    logic               is_padding;
    logic               end_of_burst;
  } out_item_t;

  typedef struct packed {
    logic              has_prev;
    logic [TotalW-1:0] prev_total;
    logic              has_cur;
    logic [TotalW-1:0] cur_total;
    logic              pad;
  } queue_entry_t;

endpackage

`default_nettype wire

>>> design/irtc_front.sv
// ----------------------------------------------------------------------------
// IR timing to carrier periods: front end
// Accepts timing items, merges zero-joined entries and queues finished pulses.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module irtc_front import irtc_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  input  wire in_item_t     in_item_i,
  input  wire logic         q_full_i,
  output logic              q_push_o,
  output queue_entry_t      q_entry_o
);

  logic [TotalW-1:0] total_q, total_d;
  logic              pend_valid_q, pend_valid_d;
  logic              merge_q, merge_d;
  logic              odd_q, odd_d;

  logic              accept;
  logic [TotalW:0]   sum;
  logic              emit_prev;
  logic              odd_after;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  always_comb begin
    sum          = {1'b0, total_q} + {{(TotalW+1-DurW){1'b0}}, in_item_i.duration_us};
    total_d      = total_q;
    pend_valid_d = pend_valid_q;
    merge_d      = merge_q;
    emit_prev    = 1'b0;
    priority if (merge_q) begin
      total_d = sum[TotalW] ? {TotalW{1'b1}} : sum[TotalW-1:0];
      merge_d = 1'b0;
    end else if (pend_valid_q && (in_item_i.duration_us == '0) &&
                 !in_item_i.last_of_burst) begin
      merge_d = 1'b1;
    end else begin
      emit_prev    = pend_valid_q;
      total_d      = {{(TotalW-DurW){1'b0}}, in_item_i.duration_us};
      pend_valid_d = 1'b1;
    end
    odd_after = odd_q ^ emit_prev;
    odd_d     = odd_after;

    q_entry_o.has_prev   = emit_prev;
    q_entry_o.prev_total = total_q;
    q_entry_o.has_cur    = in_item_i.last_of_burst;
    q_entry_o.cur_total  = total_d;
    q_entry_o.pad        = in_item_i.last_of_burst && !odd_after;
    q_push_o             = accept && (emit_prev || in_item_i.last_of_burst);

    if (in_item_i.last_of_burst) begin
      total_d      = '0;
      pend_valid_d = 1'b0;
      merge_d      = 1'b0;
      odd_d        = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q      <= '0;
      pend_valid_q <= 1'b0;
      merge_q      <= 1'b0;
      odd_q        <= 1'b0;
    end else if (accept) begin
      total_q      <= total_d;
      pend_valid_q <= pend_valid_d;
      merge_q      <= merge_d;
      odd_q        <= odd_d;
    end
  end

  a_merge_needs_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    merge_q |-> pend_valid_q)
    else $error("merge armed without a pulse in progress");

  a_pad_only_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_push_o && q_entry_o.pad) |-> q_entry_o.has_cur)
    else $error("padding queued without a final pulse");

  a_clear_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_item_i.last_of_burst) |=> (!pend_valid_q && !merge_q && !odd_q))
    else $error("burst state not cleared after the final item");

endmodule

`default_nettype wire

>>> design/irtc_fifo.sv
// ----------------------------------------------------------------------------
// IR timing to carrier periods: pulse queue
// Short first-in first-out queue between the front end and the converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module irtc_fifo import irtc_pkg::*; #(
  parameter int unsigned Depth = QUEUE_DEPTH_DEFAULT
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire queue_entry_t entry_i,
  output logic              full_o,
  input  wire logic         pop_i,
  output queue_entry_t      head_o,
  output logic              empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  queue_entry_t      mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;

  assign full_o  = (count_q == FullCnt);
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from an empty queue");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCnt)
    else $error("queue count beyond depth");

endmodule

`default_nettype wire

>>> design/irtc_back.sv
// ----------------------------------------------------------------------------
// IR timing to carrier periods: back end
// Issues pulses one per cycle unless stalled; turns microseconds into periods.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module irtc_back import irtc_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire queue_entry_t        head_i,
  input  wire logic                head_valid_i,
  output logic                     pop_o,
  input  wire logic [CarrierW-1:0] carrier_hz_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output out_item_t                out_item_o
);

  typedef enum logic [1:0] {
    SLOT_PREV,
    SLOT_CUR,
    SLOT_PAD
  } slot_e;

  slot_e slot_q, slot_d, kind, next_kind;

  logic              en;
  logic              issue;
  logic              done;
  logic [TotalW-1:0] iss_total;
  logic              iss_pad, iss_end;

  logic [4:0] v_q;
  logic [3:0] pad_q, end_q;

  logic [34:0]        ph_q, pl_q;
  logic [50:0]        x;
  logic [44:0]        y2_q, y3_q;
  logic [63:0]        prod;
  logic [31:0]        q0_3_q, q0_4_q;
  logic [45:0]        mul4;
  logic [16:0]        r4_q;
  logic [PeriodW-1:0] q5;

  out_item_t          out_q;
  logic [PeriodW-1:0] last_q;

  assign en    = !(v_q[4] && out_stall_i);
  assign issue = en && head_valid_i;

  always_comb begin
    kind = (slot_q == SLOT_PREV && !head_i.has_prev) ? SLOT_CUR : slot_q;
    unique case (kind)
      SLOT_PREV: begin
        iss_total = head_i.prev_total;
        iss_pad   = 1'b0;
        iss_end   = 1'b0;
        done      = !head_i.has_cur;
        next_kind = SLOT_CUR;
      end
      SLOT_CUR: begin
        iss_total = head_i.cur_total;
        iss_pad   = 1'b0;
        iss_end   = !head_i.pad;
        done      = !head_i.pad;
        next_kind = SLOT_PAD;
      end
      default: begin
        iss_total = '0;
        iss_pad   = 1'b1;
        iss_end   = 1'b1;
        done      = 1'b1;
        next_kind = SLOT_PREV;
      end
    endcase
    slot_d = done ? SLOT_PREV : next_kind;
    pop_o  = issue && done;
  end

  always_comb begin
    x    = {ph_q, 16'b0} + {16'b0, pl_q} + {31'b0, RoundBias};
    prod = {32'b0, y2_q[44:13]} * {32'b0, Reciprocal};
    mul4 = {14'b0, q0_3_q} * {32'b0, Divisor};
    if (r4_q >= DivisorX2) begin
      q5 = q0_4_q + 32'd2;
    end else if (r4_q >= {1'b0, DivisorX1}) begin
      q5 = q0_4_q + 32'd1;
    end else begin
      q5 = q0_4_q;
    end
    if (q5 == '0) begin
      q5 = 32'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= SLOT_PREV;
      v_q    <= '0;
    end else if (en) begin
      if (issue) begin
        slot_q <= slot_d;
      end
      v_q <= {v_q[3:0], issue};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ph_q   <= 35'(iss_total[31:16]) * 35'(carrier_hz_i);
      pl_q   <= 35'(iss_total[15:0]) * 35'(carrier_hz_i);
      pad_q  <= {pad_q[2:0], iss_pad};
      end_q  <= {end_q[2:0], iss_end};
      y2_q   <= x[50:6];
      y3_q   <= y2_q;
      q0_3_q <= prod[63:32];
      q0_4_q <= q0_3_q;
      r4_q   <= y3_q[16:0] - mul4[16:0];
      if (v_q[3]) begin
        out_q.carrier_periods <= pad_q[3] ? last_q : q5;
        out_q.is_padding      <= pad_q[3];
        out_q.end_of_burst    <= end_q[3];
        if (!pad_q[3]) begin
          last_q <= q5;
        end
      end
    end
  end

  assign out_valid_o = v_q[4];
  assign out_item_o  = out_q;

  a_issue_from_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> head_valid_i)
    else $error("queue popped while empty");

  a_periods_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.carrier_periods != '0))
    else $error("zero carrier periods on output");

  a_padding_ends_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.is_padding) |-> out_item_o.end_of_burst)
    else $error("padding result not marked as end of burst");

endmodule

`default_nettype wire

>>> design/ir_timing_to_carrier_periods_core.sv
// ----------------------------------------------------------------------------
// IR timing to carrier periods: top level
// Converts bursts of IR mark/space durations into carrier period counts.
// ----------------------------------------------------------------------------
//  Port group   Direction  Handshake                   Payload
//  in_*         in         in_valid_i / in_stall_o     in_item_i (in_item_t)
//  out_*        out        out_valid_o / out_stall_i   out_item_o (out_item_t)
//  APB          in/out     psel, penable, pready       carrier_hz at address 0
//
//  One item is accepted per cycle while the pulse queue has room.
//  A final item can produce up to three results, which the converter issues
//  one per cycle unless stalled, so the queue absorbs the extra cycles at
//  each burst end. Results pass the product, sum, quotient, remainder and output
//  registers; the pipeline freezes as a whole while its output register stalls.
//  Reset clears all burst state and sets the carrier to 38000 Hz.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ir_timing_to_carrier_periods_core import irtc_pkg::*; #(
  parameter int unsigned QueueDepth = QUEUE_DEPTH_DEFAULT
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire in_item_t    in_item_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output out_item_t        out_item_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [CarrierW-1:0] carrier_q;
  logic [CarrierW-1:0] carrier_d;
  logic                cfg_wr;

  queue_entry_t q_entry, q_head;
  logic         q_push, q_pop, q_full, q_empty;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == RegIdxCarrierHz);

  always_comb begin
    carrier_d = pwdata[CarrierW-1:0];
    if (carrier_d < CarrierMin) begin
      carrier_d = CarrierMin;
    end else if (carrier_d > CarrierMax) begin
      carrier_d = CarrierMax;
    end
    prdata = (paddr[2] == RegIdxCarrierHz) ? {{(32-CarrierW){1'b0}}, carrier_q} : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carrier_q <= CarrierReset;
    end else if (cfg_wr) begin
      carrier_q <= carrier_d;
    end
  end

  irtc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_entry_o  (q_entry)
  );

  irtc_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .head_o  (q_head),
    .empty_o (q_empty)
  );

  irtc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (q_head),
    .head_valid_i (!q_empty),
    .pop_o        (q_pop),
    .carrier_hz_i (carrier_q),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_item_o   (out_item_o)
  );

endmodule

`default_nettype wire
